@@ sv/irad_pkg.sv @@
// ----------------------------------------------------------------------------
// irad_pkg
// Shared types, constants and helpers for the integer to ascii radix block.
// ----------------------------------------------------------------------------
package irad_pkg;

   localparam int RADIX_W   = 6;
   localparam int DIGIT_W   = 6;
   localparam int CHAR_W    = 7;
   localparam int REM_W     = 7;
   localparam int STEP_BITS = 4;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   localparam logic [DIGIT_W-1:0] LAST_DECIMAL_DIGIT = 6'd9;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO          = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_LETTER_BASE   = 7'd55;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // request handed from the front queue to the conversion engine
   typedef struct packed {
      logic               valid;
      logic [RADIX_W-1:0] radix;
   } job_ctl_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {1'b0, d};
      if (d > LAST_DECIMAL_DIGIT) begin
         return d_ext + CHAR_LETTER_BASE;
      end
      return d_ext + CHAR_ZERO;
   endfunction

endpackage

@@ sv/integer_to_ascii_radix.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Unsigned integer to ASCII text in a programmable radix.
// ----------------------------------------------------------------------------
// Requests enter through req_push/req_full; a request is taken on a clock
// edge with req_push high and req_full low. Each request carries one number,
// req_value, and produces one character per digit on rsp_ascii_char, most
// significant first, with rsp_last_char set on the final digit. A character
// is shown while rsp_empty is low and is taken when rsp_pop is high.
// csr_write_data sets the radix; 0 and 1 act as 2, 37..63 act as 36. The
// radix is sampled when a request is taken. Only write it while idle.
// Conversion runs each digit through the shared divider (four quotient
// bits a cycle), then sends one character a cycle while rsp_pop is high,
// then returns to idle to pick up the next request.
// Numbers needing more than MAX_DIGITS digits send only the low digits.
// A two-entry request queue keeps taking requests while characters wait;
// a stalled receiver holds the current character and the divider.
// Reset empties the queue, drops any conversion and sets the radix to 10.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
   parameter int VALUE_BITS = 16,
   parameter int MAX_DIGITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [VALUE_BITS-1:0]         req_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [irad_pkg::CHAR_W-1:0]   rsp_ascii_char,
   output logic                          rsp_last_char,
   input  logic                          csr_write_enable,
   input  logic [irad_pkg::RADIX_W-1:0]  csr_write_data
);
   import irad_pkg::*;

   job_ctl_type           job_ctl;
   logic [VALUE_BITS-1:0] job_value;
   logic                  job_ready;

   irad_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_value       (req_value),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .job_ctl         (job_ctl),
      .job_value       (job_value),
      .job_ready       (job_ready)
   );

   irad_engine #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .job_ctl       (job_ctl),
      .job_value     (job_value),
      .job_ready     (job_ready),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_ascii_char(rsp_ascii_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

@@ sv/irad_front.sv @@
// ----------------------------------------------------------------------------
// irad_front
// Radix register, request intake with radix saturation and a two-entry queue.
// ----------------------------------------------------------------------------
module irad_front #(
   parameter int VALUE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [VALUE_BITS-1:0]      req_value,
   input  logic                       csr_write_enable,
   input  logic [irad_pkg::RADIX_W-1:0] csr_write_data,
   output irad_pkg::job_ctl_type      job_ctl,
   output logic [VALUE_BITS-1:0]      job_value,
   input  logic                       job_ready
);
   import irad_pkg::*;

   logic [RADIX_W-1:0]    radix_ff;
   logic [RADIX_W-1:0]    radix_eff;
   logic [VALUE_BITS-1:0] val_q_ff [2];
   logic [RADIX_W-1:0]    rad_q_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_write_enable) begin
         radix_ff <= csr_write_data;
      end
   end

   // out-of-range bases saturate to the nearest legal one
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         radix_eff = RADIX_MAX;
      end else begin
         radix_eff = radix_ff;
      end
   end

   assign req_full = (cnt_ff == 2'd2);
   assign do_push  = req_push && !req_full;
   assign do_pop   = job_ready && (cnt_ff != 2'd0);

   assign job_ctl.valid = (cnt_ff != 2'd0);
   assign job_ctl.radix = rad_q_ff[rd_ptr_ff];
   assign job_value     = val_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         val_q_ff[wr_ptr_ff] <= req_value;
         rad_q_ff[wr_ptr_ff] <= radix_eff;
      end
   end

endmodule

@@ sv/irad_engine.sv @@
// ----------------------------------------------------------------------------
// irad_engine
// Repeated division by the radix, four quotient bits a cycle, digits kept
// on a stack and sent out most significant first.
// ----------------------------------------------------------------------------
module irad_engine #(
   parameter int VALUE_BITS = 16,
   parameter int MAX_DIGITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  irad_pkg::job_ctl_type       job_ctl,
   input  logic [VALUE_BITS-1:0]       job_value,
   output logic                        job_ready,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [irad_pkg::CHAR_W-1:0] rsp_ascii_char,
   output logic                        rsp_last_char
);
   import irad_pkg::*;

   localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_W      = DIV_CYCLES * STEP_BITS;
   localparam int CYC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

   state_type          state_ff, state_in;
   logic [PAD_W-1:0]   quot_ff, quot_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [CYC_W-1:0]   cyc_ff, cyc_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DIGIT_W-1:0] stack_ff [MAX_DIGITS];

   logic [PAD_W-1:0]     quot_next;
   logic [REM_W-1:0]     rem_next;
   logic [STEP_BITS-1:0] qbits;
   logic                 push_digit;
   logic                 pop_digit;

   // four restoring division steps on the top dividend bits
   always_comb begin
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] t;
      r     = rem_ff;
      qbits = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         t = {r[REM_W-2:0], quot_ff[PAD_W-1-i]};
         if (t >= {1'b0, radix_ff}) begin
            r                    = t - {1'b0, radix_ff};
            qbits[STEP_BITS-1-i] = 1'b1;
         end else begin
            r = t;
         end
      end
      rem_next  = r;
      quot_next = (quot_ff << STEP_BITS) | PAD_W'(qbits);
   end

   assign rsp_empty      = (state_ff != ST_EMIT);
   assign rsp_ascii_char = digit_to_ascii(stack_ff[0]);
   assign rsp_last_char  = (count_ff == CNT_W'(1));
   assign pop_digit      = (state_ff == ST_EMIT) && rsp_pop;

   always_comb begin
      state_in   = state_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      radix_in   = radix_ff;
      cyc_in     = cyc_ff;
      count_in   = count_ff;
      job_ready  = 1'b0;
      push_digit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_ctl.valid) begin
               quot_in  = PAD_W'(job_value);
               rem_in   = '0;
               radix_in = job_ctl.radix;
               cyc_in   = '0;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quot_in = quot_next;
            rem_in  = rem_next;
            if (cyc_ff == CYC_W'(DIV_CYCLES - 1)) begin
               push_digit = 1'b1;
               count_in   = count_ff + CNT_W'(1);
               rem_in     = '0;
               cyc_in     = '0;
               // stop on a zero quotient or a full digit stack
               if ((quot_next == '0) || (count_ff + CNT_W'(1) == CNT_W'(MAX_DIGITS))) begin
                  state_in = ST_EMIT;
               end
            end else begin
               cyc_in = cyc_ff + CYC_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_pop) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cyc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cyc_ff   <= cyc_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   // newest digit enters at the top, so the top is always the next to send
   always_ff @(posedge clock) begin
      if (push_digit) begin
         stack_ff[0] <= rem_next[DIGIT_W-1:0];
         for (int i = 1; i < MAX_DIGITS; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (pop_digit) begin
         for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

endmodule
